// ===== rtl/stepper_driver_fault_monitor_unit_macros.svh =====
// Assertion macros shared by the checker of the stepper driver fault monitor.
`ifndef STEPPER_DRIVER_FAULT_MONITOR_UNIT_MACROS_SVH
`define STEPPER_DRIVER_FAULT_MONITOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdfm check failed");

// Consequent must hold in the cycle after the antecedent.
`define SDFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdfm check failed");

`endif

// ===== rtl/sdfm_pkg.sv =====
// Shared types, constants and helper functions of the stepper driver fault monitor.
package sdfm_pkg;

  localparam int DRIVERS = 13;
  localparam int DRV_W   = (DRIVERS > 1) ? $clog2(DRIVERS) : 1;

  localparam int DRIVER_W  = 4;
  localparam int STATUS_W  = 16;
  localparam int LEVEL_W   = 8;
  localparam int STEP_W    = 7;
  localparam int LINK_W    = 8;
  localparam int WARN_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Status bit positions, after inversion a set bit is an active condition.
  localparam int BIT_HIZ   = 0;
  localparam int BIT_UVLO  = 9;
  localparam int BIT_THWRN = 10;
  localparam int BIT_THSD  = 11;
  localparam int BIT_OCD   = 12;
  localparam int BIT_LOSSA = 13;
  localparam int BIT_LOSSB = 14;

  localparam logic [LINK_W-1:0] LINK_REPEAT = LINK_W'(240);
  localparam logic [WARN_W-1:0] WARN_LIMIT  = WARN_W'(4);

  // Reset values of the configuration registers.
  localparam logic [STATUS_W-1:0] MASK_RESET    = 16'h7E00;
  localparam logic [STEP_W-1:0]   STEP_RESET    = STEP_W'(1);
  localparam logic [LEVEL_W-1:0]  DEFAULT_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERROR_MASK    = 2'd0,
    CFG_HOLD_STEP     = 2'd1,
    CFG_HOLD_DEFAULT  = 2'd2,
    CFG_STOP_ON_ERROR = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_LOST    = 3'd1,
    EV_REMIND  = 3'd2,
    EV_RESTORE = 3'd3,
    EV_FAULT   = 3'd4
  } event_t;

  // Decoded view of one status word.
  typedef struct packed {
    logic link_lost;
    logic fault;
    logic hiz;
    logic thsd;
    logic thwrn;
    logic ocd;
    logic loss;
    logic uvlo;
    logic stop;
  } decode_t;

  typedef struct packed {
    event_t              event_res;
    logic [LEVEL_W-1:0]  hold_level;
    logic                level_reduced;
    logic                shut_down;
    logic                over_temp;
    logic                temp_warning;
    logic                overcurrent;
    logic                stalled;
    logic                under_voltage;
    logic                stop_request;
  } result_t;

  // Subtract and stop at zero.
  function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] level,
                                                  input logic [LEVEL_W-1:0] amount);
    sat_sub = (amount >= level) ? '0 : LEVEL_W'(level - amount);
  endfunction

endpackage

// ===== rtl/sdfm_channels.sv =====
// Valid/ready channel interfaces for status polls and fault reports.
interface sdfm_poll_if;
  logic                             valid;
  logic                             ready;
  logic [sdfm_pkg::DRIVER_W-1:0]    driver;
  logic [sdfm_pkg::STATUS_W-1:0]    status_word;

  modport source (output valid, output driver, output status_word, input ready);
  modport sink   (input valid, input driver, input status_word, output ready);
endinterface

interface sdfm_report_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       event_res;
  logic [sdfm_pkg::LEVEL_W-1:0]     hold_level;
  logic                             level_reduced;
  logic                             shut_down;
  logic                             over_temp;
  logic                             temp_warning;
  logic                             overcurrent;
  logic                             stalled;
  logic                             under_voltage;
  logic                             stop_request;

  modport source (output valid, output event_res, output hold_level, output level_reduced,
                  output shut_down, output over_temp, output temp_warning,
                  output overcurrent, output stalled, output under_voltage,
                  output stop_request, input ready);
  modport sink   (input valid, input event_res, input hold_level, input level_reduced,
                  input shut_down, input over_temp, input temp_warning,
                  input overcurrent, input stalled, input under_voltage,
                  input stop_request, output ready);
endinterface

// ===== rtl/sdfm_decode.sv =====
// Status word decoder: link loss, masked fault test and individual fault bits.
module sdfm_decode (
  input  logic [sdfm_pkg::STATUS_W-1:0] status_word,
  input  logic [sdfm_pkg::STATUS_W-1:0] error_mask,
  input  logic                          stop_on_error,
  output sdfm_pkg::decode_t             dec
);

  logic [sdfm_pkg::STATUS_W-1:0] inv;

  assign inv = ~status_word;

  always_comb begin
    dec.link_lost = (status_word == '0) || (status_word == '1);
    dec.fault     = |(inv & error_mask);
    dec.hiz       = inv[sdfm_pkg::BIT_HIZ];
    dec.thsd      = inv[sdfm_pkg::BIT_THSD];
    dec.thwrn     = inv[sdfm_pkg::BIT_THWRN];
    dec.ocd       = inv[sdfm_pkg::BIT_OCD];
    dec.loss      = inv[sdfm_pkg::BIT_LOSSA] | inv[sdfm_pkg::BIT_LOSSB];
    dec.uvlo      = inv[sdfm_pkg::BIT_UVLO];
    dec.stop      = stop_on_error &
                    (inv[sdfm_pkg::BIT_UVLO] | inv[sdfm_pkg::BIT_THWRN] |
                     inv[sdfm_pkg::BIT_THSD]);
  end

endmodule

// ===== rtl/sdfm_state.sv =====
// Per-driver state registers and the read-modify-write step that updates them.
module sdfm_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [sdfm_pkg::DRIVER_W-1:0] driver,
  input  sdfm_pkg::decode_t             dec,
  input  logic [sdfm_pkg::STEP_W-1:0]   hold_step_down,
  input  logic [sdfm_pkg::LEVEL_W-1:0]  hold_default,
  output sdfm_pkg::result_t             res
);

  logic [sdfm_pkg::LINK_W-1:0]  link_count [sdfm_pkg::DRIVERS];
  logic [sdfm_pkg::WARN_W-1:0]  warn_count [sdfm_pkg::DRIVERS];
  logic [sdfm_pkg::LEVEL_W-1:0] hold_store [sdfm_pkg::DRIVERS];

  logic                          in_range;
  logic [sdfm_pkg::DRV_W-1:0]    idx;
  logic [sdfm_pkg::LINK_W-1:0]   lc, lc_inc, link_count_next;
  logic [sdfm_pkg::WARN_W-1:0]   wc, wc_inc, warn_count_next;
  logic [sdfm_pkg::LEVEL_W-1:0]  level_prev, h_sd, h_warn, hold_next;
  logic [sdfm_pkg::LEVEL_W-1:0]  step8;
  logic                          reinit, fault_ev;

  assign in_range   = {1'b0, driver} < (sdfm_pkg::DRIVER_W + 1)'(sdfm_pkg::DRIVERS);
  assign idx        = driver[sdfm_pkg::DRV_W-1:0];
  assign lc         = link_count[idx];
  assign wc         = warn_count[idx];
  assign level_prev = hold_store[idx];
  assign lc_inc     = lc + 1'b1;
  assign wc_inc     = wc + 1'b1;
  assign step8      = {1'b0, hold_step_down};

  // Thermal shutdown drops twice the step, then a long warning run drops one more step.
  assign h_sd   = (dec.hiz && dec.thsd) ?
                  sdfm_pkg::sat_sub(level_prev, {hold_step_down, 1'b0}) : level_prev;
  assign h_warn = (dec.thwrn && (wc_inc > sdfm_pkg::WARN_LIMIT)) ?
                  sdfm_pkg::sat_sub(h_sd, step8) : h_sd;

  always_comb begin
    res             = '0;
    res.event_res   = sdfm_pkg::EV_NONE;
    link_count_next = lc;
    warn_count_next = wc;
    hold_next       = level_prev;
    reinit          = 1'b0;
    fault_ev        = 1'b0;
    if (in_range) begin
      if (dec.link_lost) begin
        if (lc == '0) begin
          link_count_next = sdfm_pkg::LINK_W'(1);
          res.event_res   = sdfm_pkg::EV_LOST;
        end else if (lc_inc > sdfm_pkg::LINK_REPEAT) begin
          link_count_next = sdfm_pkg::LINK_W'(1);
          res.event_res   = sdfm_pkg::EV_REMIND;
        end else begin
          link_count_next = lc_inc;
        end
        res.hold_level = level_prev;
      end else if (lc != '0) begin
        link_count_next = '0;
        reinit          = 1'b1;
        res.event_res   = sdfm_pkg::EV_RESTORE;
        res.hold_level  = hold_default;
      end else if (dec.fault) begin
        fault_ev          = 1'b1;
        res.event_res     = sdfm_pkg::EV_FAULT;
        hold_next         = h_warn;
        res.hold_level    = h_warn;
        res.level_reduced = h_warn < level_prev;
        res.shut_down     = dec.hiz;
        res.over_temp     = dec.hiz & dec.thsd;
        res.temp_warning  = dec.thwrn;
        res.overcurrent   = dec.ocd;
        res.stalled       = dec.loss;
        res.under_voltage = dec.uvlo;
        res.stop_request  = dec.stop;
        if (!dec.thwrn || (wc_inc > sdfm_pkg::WARN_LIMIT)) begin
          warn_count_next = '0;
        end else begin
          warn_count_next = wc_inc;
        end
      end else begin
        res.hold_level = level_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sdfm_pkg::DRIVERS; i++) begin
        link_count[i] <= '0;
        warn_count[i] <= '0;
        hold_store[i] <= '0;
      end
    end else if (fire && in_range) begin
      link_count[idx] <= link_count_next;
      if (fault_ev) begin
        warn_count[idx] <= warn_count_next;
        hold_store[idx] <= hold_next;
      end
      if (reinit) begin
        for (int i = 0; i < sdfm_pkg::DRIVERS; i++) begin
          hold_store[i] <= hold_default;
        end
      end
    end
  end

endmodule

// ===== rtl/stepper_driver_fault_monitor_unit.sv =====
// Top level of the stepper driver fault monitor: channels, configuration and pipeline.
//
//   Channel   Direction  Contents
//   poll      in         driver index, raw status word (error bits active low)
//   report    out        event code, hold level, decoded fault flags
//   wr_*      in         configuration writes: mask, hold step, hold default, stop enable
//
// An item waits in the input register; when it leaves, its result is loaded
// into the result register, which drives report. With report ready, a new item
// can be accepted every cycle. The per-driver state is read and written in the
// cycle the item leaves the input register, which lets the next item for the
// same driver see the updated values without any bypass.
// A stall on report holds the result register and then the input register;
// poll stays ready while either register has room.
// Reset clears every per-driver counter and hold level to zero and restores the
// configuration registers to their reset values.
module stepper_driver_fault_monitor_unit (
  input  logic                           clk,
  input  logic                           rst,
  sdfm_poll_if.sink                      poll,
  sdfm_report_if.source                  report,
  input  logic                           wr_en,
  input  logic [sdfm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sdfm_pkg::CFG_DAT_W-1:0] wr_data
);

  // Configuration registers.
  logic [sdfm_pkg::STATUS_W-1:0] error_mask;
  logic [sdfm_pkg::STEP_W-1:0]   hold_step_down;
  logic [sdfm_pkg::LEVEL_W-1:0]  hold_default;
  logic                          stop_on_error;

  // Input register.
  logic                          s1_valid;
  logic [sdfm_pkg::DRIVER_W-1:0] s1_driver;
  logic [sdfm_pkg::STATUS_W-1:0] s1_status;

  // Result register.
  logic                          out_valid;
  sdfm_pkg::result_t             out_res;

  sdfm_pkg::decode_t             dec;
  sdfm_pkg::result_t             step_res;
  logic                          advance;

  // The stage moves on when the result register is empty or being emptied.
  assign advance    = s1_valid && (!out_valid || report.ready);
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_mask     <= sdfm_pkg::MASK_RESET;
      hold_step_down <= sdfm_pkg::STEP_RESET;
      hold_default   <= sdfm_pkg::DEFAULT_RESET;
      stop_on_error  <= 1'b0;
    end else if (wr_en) begin
      case (sdfm_pkg::cfg_index_t'(wr_index))
        sdfm_pkg::CFG_ERROR_MASK:    error_mask     <= wr_data;
        sdfm_pkg::CFG_HOLD_STEP:     hold_step_down <= wr_data[sdfm_pkg::STEP_W-1:0];
        sdfm_pkg::CFG_HOLD_DEFAULT:  hold_default   <= wr_data[sdfm_pkg::LEVEL_W-1:0];
        sdfm_pkg::CFG_STOP_ON_ERROR: stop_on_error  <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_driver <= poll.driver;
      s1_status <= poll.status_word;
    end
  end

  sdfm_decode u_decode (
    .status_word   (s1_status),
    .error_mask    (error_mask),
    .stop_on_error (stop_on_error),
    .dec           (dec)
  );

  sdfm_state u_state (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .driver         (s1_driver),
    .dec            (dec),
    .hold_step_down (hold_step_down),
    .hold_default   (hold_default),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign report.valid         = out_valid;
  assign report.event_res     = out_res.event_res;
  assign report.hold_level    = out_res.hold_level;
  assign report.level_reduced = out_res.level_reduced;
  assign report.shut_down     = out_res.shut_down;
  assign report.over_temp     = out_res.over_temp;
  assign report.temp_warning  = out_res.temp_warning;
  assign report.overcurrent   = out_res.overcurrent;
  assign report.stalled       = out_res.stalled;
  assign report.under_voltage = out_res.under_voltage;
  assign report.stop_request  = out_res.stop_request;

endmodule

// ===== rtl/sdfm_checker.sv =====
// Port-level checker of the stepper driver fault monitor and its bind.
`include "stepper_driver_fault_monitor_unit_macros.svh"

module sdfm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rep_valid,
  input logic                          rep_ready,
  input logic [2:0]                    event_res,
  input logic [sdfm_pkg::LEVEL_W-1:0]  hold_level,
  input logic                          level_reduced,
  input logic                          shut_down,
  input logic                          over_temp,
  input logic                          temp_warning,
  input logic                          overcurrent,
  input logic                          stalled,
  input logic                          under_voltage,
  input logic                          stop_request
);

  logic is_fault;
  logic any_flag;

  assign is_fault = event_res == sdfm_pkg::EV_FAULT;
  assign any_flag = shut_down | over_temp | temp_warning | overcurrent |
                    stalled | under_voltage | stop_request;

  // Decoded fault flags appear only in fault reports.
  `SDFM_ASSERT_NOW(a_flags_only_on_fault, rep_valid && !is_fault, !any_flag)

  // A level drop only happens while handling a fault.
  `SDFM_ASSERT_NOW(a_reduce_only_on_fault, rep_valid && level_reduced, is_fault)

  // Thermal shutdown is reported only together with the shutdown bit.
  `SDFM_ASSERT_NOW(a_overtemp_needs_shutdown, rep_valid && over_temp, shut_down)

  // A stalled result stays in place.
  `SDFM_ASSERT_NEXT(a_stall_holds, rep_valid && !rep_ready,
                    rep_valid && $stable(event_res) && $stable(hold_level))

endmodule

bind stepper_driver_fault_monitor_unit sdfm_checker u_sdfm_checker (
  .clk           (clk),
  .rst           (rst),
  .rep_valid     (report.valid),
  .rep_ready     (report.ready),
  .event_res     (report.event_res),
  .hold_level    (report.hold_level),
  .level_reduced (report.level_reduced),
  .shut_down     (report.shut_down),
  .over_temp     (report.over_temp),
  .temp_warning  (report.temp_warning),
  .overcurrent   (report.overcurrent),
  .stalled       (report.stalled),
  .under_voltage (report.under_voltage),
  .stop_request  (report.stop_request)
);

// ===== tb/sv/stepper_driver_fault_monitor_unit_checker.sv =====
// Checker that predicts every report from the polls and compares it with the block's output.
module stepper_driver_fault_monitor_unit_checker
  import sdfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sdfm_poll_if                 poll,
  sdfm_report_if               report,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output int                   failures,
  output int                   outstanding,
  output int                   reports_checked,
  output int                   reminders_seen,
  output int                   reductions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_MISMATCHES = 10;

  // Configuration as the block should hold it.
  logic [STATUS_W-1:0] mask_r;
  logic [STEP_W-1:0]   step_r;
  logic [LEVEL_W-1:0]  default_r;
  logic                stop_r;

  // Per-driver state that shapes the reports; the status history itself is never visible.
  logic [LINK_W-1:0]  lost_run [DRIVERS];
  logic [WARN_W-1:0]  warn_run [DRIVERS];
  logic [LEVEL_W-1:0] hold_lvl [DRIVERS];

  result_t pending_reports[$];
  int      mismatches = 0;
  int      checked = 0;
  int      reminders = 0;
  int      reductions = 0;

  function automatic result_t predict_report(input logic [DRIVER_W-1:0] drv,
                                             input logic [STATUS_W-1:0] word);
    result_t             r;
    logic [STATUS_W-1:0] active;
    logic [LEVEL_W-1:0]  start_level;
    int                  lvl;
    r = '0;
    if (drv >= DRIVERS) begin
      return r;
    end
    active = ~word;
    start_level = hold_lvl[drv];
    if (word == '0 || word == '1) begin
      if (lost_run[drv] == '0) begin
        lost_run[drv] = LINK_W'(1);
        r.event_res = EV_LOST;
      end else if (lost_run[drv] == LINK_REPEAT) begin
        lost_run[drv] = LINK_W'(1);
        r.event_res = EV_REMIND;
      end else begin
        lost_run[drv] = lost_run[drv] + LINK_W'(1);
      end
    end else if (lost_run[drv] != '0) begin
      // The link came back: every driver gets the default hold level again.
      lost_run[drv] = '0;
      foreach (hold_lvl[i]) hold_lvl[i] = default_r;
      start_level = default_r;
      r.event_res = EV_RESTORE;
    end else if ((active & mask_r) != '0) begin
      r.event_res = EV_FAULT;
      lvl = int'(hold_lvl[drv]);
      if (active[BIT_HIZ]) begin
        r.shut_down = 1'b1;
        if (active[BIT_THSD]) begin
          r.over_temp = 1'b1;
          lvl = lvl - 2 * int'(step_r);
        end
      end
      if (active[BIT_THWRN]) begin
        r.temp_warning = 1'b1;
        if (warn_run[drv] == WARN_LIMIT) begin
          lvl = lvl - int'(step_r);
          warn_run[drv] = '0;
        end else begin
          warn_run[drv] = warn_run[drv] + WARN_W'(1);
        end
      end else begin
        warn_run[drv] = '0;
      end
      // Clamping once at the end equals clamping after each of the two drops.
      hold_lvl[drv] = (lvl < 0) ? '0 : LEVEL_W'(lvl);
      r.overcurrent = active[BIT_OCD];
      r.stalled = active[BIT_LOSSA] | active[BIT_LOSSB];
      r.under_voltage = active[BIT_UVLO];
      r.stop_request = stop_r & (active[BIT_UVLO] | active[BIT_THWRN] | active[BIT_THSD]);
    end
    r.hold_level = hold_lvl[drv];
    r.level_reduced = (hold_lvl[drv] < start_level);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    logic    bad;
    if (rst) begin
      mask_r = MASK_RESET;
      step_r = STEP_RESET;
      default_r = DEFAULT_RESET;
      stop_r = 1'b0;
      foreach (lost_run[i]) begin
        lost_run[i] = '0;
        warn_run[i] = '0;
        hold_lvl[i] = '0;
      end
      pending_reports.delete();
    end else begin
      if (wr_en) begin
        case (cfg_index_t'(wr_index))
          CFG_ERROR_MASK:    mask_r = wr_data;
          CFG_HOLD_STEP:     step_r = wr_data[STEP_W-1:0];
          CFG_HOLD_DEFAULT:  default_r = wr_data[LEVEL_W-1:0];
          CFG_STOP_ON_ERROR: stop_r = wr_data[0];
          default: ;
        endcase
      end
      // Retire a report before predicting, so a new poll can never pair with it.
      if (report.valid === 1'b1 && report.ready === 1'b1) begin
        checked++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("report %0d arrived with no poll waiting: event %0d level %0d",
                     checked, report.event_res, report.hold_level);
          end
        end else begin
          exp_r = pending_reports.pop_front();
          bad = (report.event_res !== exp_r.event_res)
             || (report.hold_level !== exp_r.hold_level)
             || (report.level_reduced !== exp_r.level_reduced)
             || (report.shut_down !== exp_r.shut_down)
             || (report.over_temp !== exp_r.over_temp)
             || (report.temp_warning !== exp_r.temp_warning)
             || (report.overcurrent !== exp_r.overcurrent)
             || (report.stalled !== exp_r.stalled)
             || (report.under_voltage !== exp_r.under_voltage)
             || (report.stop_request !== exp_r.stop_request);
          if (bad) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
              $display({"report %0d mismatch: expected event %0d level %0d reduced %b flags %b,",
                        " got event %0d level %0d reduced %b flags %b"},
                       checked, exp_r.event_res, exp_r.hold_level, exp_r.level_reduced,
                       {exp_r.shut_down, exp_r.over_temp, exp_r.temp_warning,
                        exp_r.overcurrent, exp_r.stalled, exp_r.under_voltage,
                        exp_r.stop_request},
                       report.event_res, report.hold_level, report.level_reduced,
                       {report.shut_down, report.over_temp, report.temp_warning,
                        report.overcurrent, report.stalled, report.under_voltage,
                        report.stop_request});
            end
          end
          if (exp_r.event_res == EV_REMIND) reminders++;
          if (exp_r.level_reduced) reductions++;
        end
      end
      if (poll.valid === 1'b1 && poll.ready === 1'b1) begin
        pending_reports.push_back(predict_report(poll.driver, poll.status_word));
      end
    end
    failures <= mismatches;
    outstanding <= pending_reports.size();
    reports_checked <= checked;
    reminders_seen <= reminders;
    reductions_seen <= reductions;
  end

endmodule

// ===== tb/sv/stepper_driver_fault_monitor_unit_tb.sv =====
// Top of the fault monitor testbench: clock, reset, polls, register writes and the verdict.
module stepper_driver_fault_monitor_unit_tb;
  import sdfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The run ends as failed when this many cycles pass with no item moving on either channel.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_OFF_CYCLES = 64;

  // Status conditions, written as set bits; a poll carries them inverted.
  localparam logic [STATUS_W-1:0] C_HIZ   = STATUS_W'(1) << BIT_HIZ;
  localparam logic [STATUS_W-1:0] C_UVLO  = STATUS_W'(1) << BIT_UVLO;
  localparam logic [STATUS_W-1:0] C_THWRN = STATUS_W'(1) << BIT_THWRN;
  localparam logic [STATUS_W-1:0] C_THSD  = STATUS_W'(1) << BIT_THSD;
  localparam logic [STATUS_W-1:0] C_OCD   = STATUS_W'(1) << BIT_OCD;
  localparam logic [STATUS_W-1:0] C_LOSSA = STATUS_W'(1) << BIT_LOSSA;
  localparam logic [STATUS_W-1:0] C_LOSSB = STATUS_W'(1) << BIT_LOSSB;
  localparam logic [STATUS_W-1:0] C_ALL   = C_HIZ | C_UVLO | C_THWRN | C_THSD
                                          | C_OCD | C_LOSSA | C_LOSSB;

  logic clk = 1'b0;
  logic rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_DAT_W-1:0] wr_data;

  sdfm_poll_if   poll_ch();
  sdfm_report_if report_ch();

  int failures;
  int outstanding;
  int reports_checked;
  int reminders_seen;
  int reductions_seen;

  // Idle chances in percent for each side, changed between phases by the main sequence.
  int tx_idle_pct = 38;
  int rx_idle_pct = 46;
  // The main sequence asks for a hold-off by bumping stall_asks; the receiver serves it.
  int stall_asks = 0;
  int stall_served = 0;
  int items_sent = 0;
  int settings_applied = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stepper_driver_fault_monitor_unit dut (
    .clk      (clk),
    .rst      (rst),
    .poll     (poll_ch),
    .report   (report_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  stepper_driver_fault_monitor_unit_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .poll            (poll_ch),
    .report          (report_ch),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .reports_checked (reports_checked),
    .reminders_seen  (reminders_seen),
    .reductions_seen (reductions_seen)
  );

  // A good status word carrying the given conditions. The bits with no meaning are
  // filled at random, and a word that happens to read as a lost link is nudged off it.
  function automatic logic [STATUS_W-1:0] make_word(input logic [STATUS_W-1:0] conds);
    logic [STATUS_W-1:0] w;
    w = ~conds;
    w[8:1] = 8'($urandom);
    w[15] = 1'($urandom);
    if (w == '0 || w == '1) w[15] = ~w[15];
    return w;
  endfunction

  function automatic logic [STATUS_W-1:0] lost_word();
    return ($urandom_range(1) == 1) ? '1 : '0;
  endfunction

  function automatic logic [STATUS_W-1:0] any_conds();
    return STATUS_W'($urandom) & C_ALL;
  endfunction

  // Offer one poll, idling first at the sender's current rate, and return on the
  // clock edge where the block takes it. Valid stays high for a following poll.
  task automatic send_poll(input logic [DRIVER_W-1:0] drv, input logic [STATUS_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      poll_ch.valid <= 1'b0;
      @(posedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.driver <= drv;
    poll_ch.status_word <= word;
    do @(posedge clk); while (poll_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Write all four registers on consecutive edges. Only called with the block idle.
  task automatic apply_settings(input logic [STATUS_W-1:0] mask, input int step,
                                input int level, input bit stop_en);
    wr_en <= 1'b1;
    wr_index <= CFG_ERROR_MASK;
    wr_data <= mask;
    @(posedge clk);
    wr_index <= CFG_HOLD_STEP;
    wr_data <= CFG_DAT_W'(step);
    @(posedge clk);
    wr_index <= CFG_HOLD_DEFAULT;
    wr_data <= CFG_DAT_W'(level);
    @(posedge clk);
    wr_index <= CFG_STOP_ON_ERROR;
    wr_data <= CFG_DAT_W'(stop_en);
    @(posedge clk);
    wr_en <= 1'b0;
    settings_applied++;
  endtask

  // Stop offering and wait until every predicted report has come back. Every poll
  // produces a report, so a short margin for the two pipeline stages is plenty.
  task automatic settle();
    poll_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic, mostly well-formed: runs of thermal warnings on one driver
  // (some long enough to hit the step-down), link losses followed by a recovery,
  // single fault words and clean polls. One pick in ten is a pure noise poll,
  // with driver indexes past the last driver included. An optional long outage
  // at the start runs past the reminder interval of the lost-link report.
  task automatic run_phase(input int count, input bit long_loss, input bit squeeze);
    int                  target;
    int                  kind;
    logic [DRIVER_W-1:0] drv;
    target = items_sent + count;
    if (long_loss) begin
      drv = DRIVER_W'($urandom_range(DRIVERS - 1));
      repeat (int'(LINK_REPEAT) + 1 + $urandom_range(4)) send_poll(drv, lost_word());
      send_poll(drv, make_word(any_conds()));
    end
    while (items_sent < target) begin
      // Halfway through, hold the receiver off while polls keep coming.
      if (squeeze && stall_asks == 0 && 2 * (target - items_sent) <= count) stall_asks++;
      kind = $urandom_range(99);
      drv = DRIVER_W'($urandom_range(DRIVERS - 1));
      if (kind < 35) begin
        repeat ($urandom_range(7, 3)) begin
          send_poll(drv, make_word(C_THWRN | (($urandom_range(3) == 0) ? any_conds() : '0)));
        end
      end else if (kind < 55) begin
        repeat ($urandom_range(4, 1)) send_poll(drv, lost_word());
        send_poll(drv, make_word(any_conds()));
      end else if (kind < 80) begin
        send_poll(drv, make_word(any_conds()));
      end else if (kind < 90) begin
        send_poll(drv, make_word('0));
      end else begin
        send_poll(DRIVER_W'($urandom_range(15)), STATUS_W'($urandom));
      end
    end
  endtask

  // Receiver: ready follows the current idle rate, except during a requested
  // hold-off, which keeps ready low.
  initial begin
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_asks) begin
        stall_served++;
        report_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      report_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: counts cycles in which nothing moves on either channel.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((poll_ch.valid === 1'b1 && poll_ch.ready === 1'b1)
          || (report_ch.valid === 1'b1 && report_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= CFG_ERROR_MASK;
    wr_data <= '0;
    poll_ch.valid <= 1'b0;
    poll_ch.driver <= '0;
    poll_ch.status_word <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The mask also takes in the hi-Z bit so that a shutdown alone
    // is a fault; the first recovery sets every hold level to 200, which leaves
    // room to see each reduction.
    apply_settings(16'h7E01, 3, 200, 1'b1);
    send_poll(DRIVER_W'(0), 16'h0000);               // link lost on the first driver
    send_poll(DRIVER_W'(0), 16'hFFFF);               // still lost, report has no event
    send_poll(DRIVER_W'(0), make_word('0));          // recovery restores every level
    send_poll(DRIVER_W'(DRIVERS - 1), 16'hFFFF);     // last driver loses its link
    send_poll(DRIVER_W'(DRIVERS - 1), make_word(C_OCD)); // a recovery wins over the fault bits
    send_poll(DRIVER_W'(DRIVERS), 16'h0000);         // index just past the last driver
    send_poll(DRIVER_W'(15), 16'hFFFF);              // highest index the field can carry
    send_poll(DRIVER_W'(14), make_word(C_HIZ));      // shutdown alone, on an unused index
    send_poll(DRIVER_W'(1), make_word(C_HIZ | C_THSD)); // thermal shutdown drops twice the step
    send_poll(DRIVER_W'(1), make_word(C_THSD));      // thermal bit without shutdown
    repeat (4) send_poll(DRIVER_W'(2), make_word(C_THWRN)); // warning streak builds up
    send_poll(DRIVER_W'(2), make_word(C_HIZ | C_THSD | C_THWRN)); // both reductions in one poll
    send_poll(DRIVER_W'(3), make_word(C_OCD));
    send_poll(DRIVER_W'(3), make_word(C_LOSSA));
    send_poll(DRIVER_W'(3), make_word(C_LOSSB));
    send_poll(DRIVER_W'(4), make_word(C_UVLO));
    send_poll(DRIVER_W'(5), make_word('0));          // clean poll
    send_poll(DRIVER_W'(6), make_word(C_ALL));       // every condition at once
    settle();

    // Largest step and default with every status bit counted: the levels hit zero fast.
    apply_settings(16'hFFFF, 127, 255, 1'b0);
    tx_idle_pct = 38;
    rx_idle_pct = 46;
    run_phase(330, 1'b1, 1'b0);
    settle();

    // No bits counted as errors and zero levels: only link events can report.
    apply_settings(16'h0000, 0, 0, 1'b1);
    tx_idle_pct = 46;
    rx_idle_pct = 38;
    run_phase(250, 1'b0, 1'b0);
    settle();

    // Reset mask with a mid-range step; the receiver holds off once in the middle.
    apply_settings(MASK_RESET, $urandom_range(40, 1), $urandom_range(255, 60), 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(250, 1'b0, 1'b1);
    settle();

    apply_settings(STATUS_W'($urandom) | C_THWRN, $urandom_range(127),
                   $urandom_range(255), 1'($urandom));
    run_phase(250, 1'b0, 1'b0);
    settle();
    repeat (8) @(posedge clk);

    $display("summary: %0d polls sent, %0d reports checked over %0d register settings",
             items_sent, reports_checked, settings_applied);
    $display("summary: %0d lost-link reminders, %0d hold level reductions, %0d hold-off",
             reminders_seen, reductions_seen, stall_served);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatching reports, %0d reports never arrived", failures, outstanding);
      $display("status: fail");
    end
    $finish;
  end

endmodule
